// ----- hdl/pps_pkg.sv -----
// Shared types and constants for the position PID controller.
`default_nettype none
package pps_pkg;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int GAIN_W    = 16;
	localparam int BAND_W    = 16;
	localparam int ILIM_W    = 31;
	localparam int OLIM_W    = 7;
	localparam int SCNT_W    = 8;
	localparam int TARGET_W  = 32;
	localparam int DRIVE_W   = 8;

	localparam logic [SCNT_W-1:0] TICKS_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_POSITION = 3'd0,
		CFG_GAIN_P          = 3'd1,
		CFG_GAIN_I          = 3'd2,
		CFG_GAIN_D          = 3'd3,
		CFG_SETTLE_BAND     = 3'd4,
		CFG_INTEGRAL_LIMIT  = 3'd5,
		CFG_OUTPUT_LIMIT    = 3'd6,
		CFG_SETTLE_COUNT    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [TARGET_W-1:0] target_position;
		logic [GAIN_W-1:0]          gain_p;
		logic [GAIN_W-1:0]          gain_i;
		logic [GAIN_W-1:0]          gain_d;
		logic [BAND_W-1:0]          settle_band;
		logic [ILIM_W-1:0]          integral_limit;
		logic [OLIM_W-1:0]          output_limit;
		logic [SCNT_W-1:0]          settle_count;
	} cfg_t;

	localparam logic signed [TARGET_W-1:0] RST_TARGET_POSITION = '0;
	localparam logic [GAIN_W-1:0] RST_GAIN_P         = 16'd4096;
	localparam logic [GAIN_W-1:0] RST_GAIN_I         = 16'd123;
	localparam logic [GAIN_W-1:0] RST_GAIN_D         = 16'd205;
	localparam logic [BAND_W-1:0] RST_SETTLE_BAND    = 16'd307;
	localparam logic [ILIM_W-1:0] RST_INTEGRAL_LIMIT = 31'd307200;
	localparam logic [OLIM_W-1:0] RST_OUTPUT_LIMIT   = 7'd127;
	localparam logic [SCNT_W-1:0] RST_SETTLE_COUNT   = 8'd100;

endpackage
`default_nettype wire

// ----- hdl/pid_position_settle.sv -----
// Position PID controller with integral reset and settle detection.
//
// Slave stream: one beat per control tick. tdata carries the measured
// position (Q.10, signed); tuser carries start_req, which begins a new move
// (clears integral, settle counter and done, seeds the previous error).
// Master stream: one beat per input beat, in order: clamped drive, position
// error and done flag. Configuration is a write port (cfg_we, cfg_index,
// cfg_data) taken in the same cycle; write it only while no beat is in flight.
// The input beat passes the error, state update, products, sum and result
// registers in that order before the result is valid.
// Throughput: one beat per cycle while the receiver does not stall; the state
// loop (integral, previous error, settle counter) closes within the state stage.
// When the receiver stalls, the five stages keep filling and s_axis_tready
// drops only once all of them hold a beat.
// Reset clears all stage valids and the controller state and loads the
// default configuration.
`default_nettype none
module pid_position_settle import pps_pkg::*; #(
	parameter int POSITION_WIDTH     = 32,
	parameter int GAIN_FRACTION_BITS = 12,
	localparam int IN_TDATA_W  = ((POSITION_WIDTH + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((POSITION_WIDTH + DRIVE_W + 1 + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // measured
	input  wire logic                   s_axis_tuser,   // start_req
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // drive, position_error, done_res
);

	localparam int PW = POSITION_WIDTH;
	localparam int IW = ((PW > ILIM_W) ? PW : ILIM_W) + 2;

	cfg_t cfg_q;

	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_o;

	logic                        start_s1;
	logic signed [PW-1:0]        err_s1;
	logic signed [PW-1:0]        err_s2;
	logic signed [PW-1:0]        deriv_s2;
	logic signed [IW-1:0]        integ_s2;
	logic                        done_s2;
	logic signed [PW+GAIN_W:0]   prod_p_s3;
	logic signed [PW+GAIN_W:0]   prod_d_s3;
	logic signed [IW+GAIN_W:0]   prod_i_s3;
	logic signed [PW-1:0]        err_s3;
	logic                        done_s3;
	logic signed [DRIVE_W-1:0]   drive_q;
	logic signed [PW-1:0]        err_q;
	logic                        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_position <= RST_TARGET_POSITION;
			cfg_q.gain_p          <= RST_GAIN_P;
			cfg_q.gain_i          <= RST_GAIN_I;
			cfg_q.gain_d          <= RST_GAIN_D;
			cfg_q.settle_band     <= RST_SETTLE_BAND;
			cfg_q.integral_limit  <= RST_INTEGRAL_LIMIT;
			cfg_q.output_limit    <= RST_OUTPUT_LIMIT;
			cfg_q.settle_count    <= RST_SETTLE_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TARGET_POSITION: cfg_q.target_position <= cfg_data[TARGET_W-1:0];
				CFG_GAIN_P:          cfg_q.gain_p          <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_I:          cfg_q.gain_i          <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_D:          cfg_q.gain_d          <= cfg_data[GAIN_W-1:0];
				CFG_SETTLE_BAND:     cfg_q.settle_band     <= cfg_data[BAND_W-1:0];
				CFG_INTEGRAL_LIMIT:  cfg_q.integral_limit  <= cfg_data[ILIM_W-1:0];
				CFG_OUTPUT_LIMIT:    cfg_q.output_limit    <= cfg_data[OLIM_W-1:0];
				CFG_SETTLE_COUNT:    cfg_q.settle_count    <= cfg_data[SCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign rdy_o = !m_axis_tvalid || m_axis_tready;
	assign rdy4  = !v4_q || rdy_o;
	assign rdy3  = !v3_q || rdy4;
	assign rdy2  = !v2_q || rdy3;
	assign rdy1  = !v1_q || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q          <= 1'b0;
			v2_q          <= 1'b0;
			v3_q          <= 1'b0;
			v4_q          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (rdy1)  v1_q          <= s_axis_tvalid;
			if (rdy2)  v2_q          <= v1_q;
			if (rdy3)  v3_q          <= v2_q;
			if (rdy4)  v4_q          <= v3_q;
			if (rdy_o) m_axis_tvalid <= v4_q;
		end
	end

	pps_error #(
		.POSITION_WIDTH(PW)
	) u_error (
		.clk             (clk),
		.en              (s_axis_tvalid && rdy1),
		.start_req       (s_axis_tuser),
		.measured        (s_axis_tdata[PW-1:0]),
		.target_position (cfg_q.target_position),
		.start_s1        (start_s1),
		.err_s1          (err_s1)
	);

	pps_state #(
		.POSITION_WIDTH(PW),
		.INTEG_WIDTH   (IW)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (v1_q && rdy2),
		.cfg      (cfg_q),
		.start_s1 (start_s1),
		.err_s1   (err_s1),
		.err_s2   (err_s2),
		.deriv_s2 (deriv_s2),
		.integ_s2 (integ_s2),
		.done_s2  (done_s2)
	);

	pps_terms #(
		.POSITION_WIDTH(PW),
		.INTEG_WIDTH   (IW)
	) u_terms (
		.clk       (clk),
		.en        (v2_q && rdy3),
		.cfg       (cfg_q),
		.err_s2    (err_s2),
		.deriv_s2  (deriv_s2),
		.integ_s2  (integ_s2),
		.done_s2   (done_s2),
		.prod_p_s3 (prod_p_s3),
		.prod_d_s3 (prod_d_s3),
		.prod_i_s3 (prod_i_s3),
		.err_s3    (err_s3),
		.done_s3   (done_s3)
	);

	pps_drive #(
		.POSITION_WIDTH    (PW),
		.INTEG_WIDTH       (IW),
		.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
	) u_drive (
		.clk          (clk),
		.arst_n       (arst_n),
		.en_s4        (v3_q && rdy4),
		.en_out       (v4_q && rdy_o),
		.vld          (m_axis_tvalid),
		.output_limit (cfg_q.output_limit),
		.prod_p_s3    (prod_p_s3),
		.prod_d_s3    (prod_d_s3),
		.prod_i_s3    (prod_i_s3),
		.err_s3       (err_s3),
		.done_s3      (done_s3),
		.drive_q      (drive_q),
		.err_q        (err_q),
		.done_q       (done_q)
	);

	assign m_axis_tdata = OUT_TDATA_W'({done_q, err_q, drive_q});

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q && m_axis_tvalid))
		else $error("input stalled with an empty stage");

endmodule
`default_nettype wire

// ----- hdl/pps_error.sv -----
// Input stage: position error against target, saturated, and start flag.
`default_nettype none
module pps_error import pps_pkg::*; #(
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic                             start_req,
	input  wire logic signed [POSITION_WIDTH-1:0] measured,
	input  wire logic signed [TARGET_W-1:0]       target_position,
	output logic                                  start_s1,
	output logic signed [POSITION_WIDTH-1:0]      err_s1
);

	localparam int PW = POSITION_WIDTH;
	localparam int DW = ((PW > TARGET_W) ? PW : TARGET_W) + 1;

	logic signed [DW-1:0] diff;
	logic                 fits;
	logic signed [PW-1:0] err_sat;

	always_comb begin
		diff = {{(DW-PW){measured[PW-1]}}, measured}
			- {{(DW-TARGET_W){target_position[TARGET_W-1]}}, target_position};
		fits = (diff[DW-1:PW-1] == {(DW-PW+1){diff[DW-1]}});
		if (fits) begin
			err_sat = diff[PW-1:0];
		end else begin
			err_sat = {diff[DW-1], {(PW-1){~diff[DW-1]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			start_s1 <= start_req;
			err_s1   <= err_sat;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/pps_state.sv -----
// Controller state: integral, previous error, settle counter and done flag.
`default_nettype none
module pps_state import pps_pkg::*; #(
	parameter int POSITION_WIDTH = 32,
	parameter int INTEG_WIDTH    = 34
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire cfg_t                             cfg,
	input  wire logic                             start_s1,
	input  wire logic signed [POSITION_WIDTH-1:0] err_s1,
	output logic signed [POSITION_WIDTH-1:0]      err_s2,
	output logic signed [POSITION_WIDTH-1:0]      deriv_s2,
	output logic signed [INTEG_WIDTH-1:0]         integ_s2,
	output logic                                  done_s2
);

	localparam int PW = POSITION_WIDTH;
	localparam int IW = INTEG_WIDTH;

	logic signed [IW-1:0] integ_q;
	logic signed [PW-1:0] prev_q;
	logic [SCNT_W-1:0]    ticks_q;
	logic                 fin_q;

	logic                 active;
	logic signed [IW-1:0] integ_eff;
	logic signed [PW-1:0] prev_eff;
	logic [SCNT_W-1:0]    ticks_eff;
	logic [PW-1:0]        err_mag;
	logic                 in_band;
	logic signed [IW-1:0] integ_base;
	logic [IW-1:0]        integ_mag;
	logic signed [IW-1:0] integ_new;
	logic signed [PW:0]   ddiff;
	logic signed [PW-1:0] deriv;
	logic [SCNT_W-1:0]    ticks_new;
	logic                 fin_new;

	always_comb begin
		active    = start_s1 || !fin_q;
		integ_eff = start_s1 ? '0 : integ_q;
		prev_eff  = start_s1 ? err_s1 : prev_q;
		ticks_eff = start_s1 ? '0 : ticks_q;

		err_mag = err_s1[PW-1] ? PW'(-err_s1) : err_s1;
		in_band = err_mag < PW'(cfg.settle_band);

		integ_base = in_band ? '0 : integ_eff;
		integ_mag  = integ_base[IW-1] ? IW'(-integ_base) : integ_base;
		if (cfg.gain_i == '0) begin
			integ_new = '0;
		end else if (integ_mag < IW'(cfg.integral_limit)) begin
			integ_new = integ_base + {{(IW-PW){err_s1[PW-1]}}, err_s1};
		end else begin
			integ_new = '0;
		end

		ddiff = {err_s1[PW-1], err_s1} - {prev_eff[PW-1], prev_eff};
		if (ddiff[PW] == ddiff[PW-1]) begin
			deriv = ddiff[PW-1:0];
		end else begin
			deriv = {ddiff[PW], {(PW-1){~ddiff[PW]}}};
		end

		if (!in_band) begin
			ticks_new = '0;
		end else if (ticks_eff == TICKS_MAX) begin
			ticks_new = TICKS_MAX;
		end else begin
			ticks_new = ticks_eff + 1'b1;
		end
		fin_new = ticks_new > cfg.settle_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
			ticks_q <= '0;
			fin_q   <= 1'b0;
		end else if (en && active) begin
			integ_q <= integ_new;
			prev_q  <= err_s1;
			ticks_q <= ticks_new;
			fin_q   <= fin_new;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s2   <= err_s1;
			deriv_s2 <= deriv;
			integ_s2 <= integ_new;
			done_s2  <= active ? fin_new : 1'b1;
		end
	end

	a_hold_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(en && fin_q && !start_s1) |=> ($stable(integ_q) && $stable(prev_q)))
		else $error("state changed while done");

	a_start_clears_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(en && start_s1) |=> (ticks_q <= SCNT_W'(1)))
		else $error("settle counter not cleared by start");

endmodule
`default_nettype wire

// ----- hdl/pps_terms.sv -----
// Gain products for the proportional, integral and derivative terms.
`default_nettype none
module pps_terms import pps_pkg::*; #(
	parameter int POSITION_WIDTH = 32,
	parameter int INTEG_WIDTH    = 34
) (
	input  wire logic                                   clk,
	input  wire logic                                   en,
	input  wire cfg_t                                   cfg,
	input  wire logic signed [POSITION_WIDTH-1:0]       err_s2,
	input  wire logic signed [POSITION_WIDTH-1:0]       deriv_s2,
	input  wire logic signed [INTEG_WIDTH-1:0]          integ_s2,
	input  wire logic                                   done_s2,
	output logic signed [POSITION_WIDTH+GAIN_W:0]       prod_p_s3,
	output logic signed [POSITION_WIDTH+GAIN_W:0]       prod_d_s3,
	output logic signed [INTEG_WIDTH+GAIN_W:0]          prod_i_s3,
	output logic signed [POSITION_WIDTH-1:0]            err_s3,
	output logic                                        done_s3
);

	localparam int PPW = POSITION_WIDTH + GAIN_W + 1;
	localparam int IPW = INTEG_WIDTH + GAIN_W + 1;

	logic signed [GAIN_W:0] gp;
	logic signed [GAIN_W:0] gi;
	logic signed [GAIN_W:0] gd;

	assign gp = {1'b0, cfg.gain_p};
	assign gi = {1'b0, cfg.gain_i};
	assign gd = {1'b0, cfg.gain_d};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_p_s3 <= PPW'(gp) * PPW'(err_s2);
			prod_d_s3 <= PPW'(gd) * PPW'(deriv_s2);
			prod_i_s3 <= IPW'(gi) * IPW'(integ_s2);
			err_s3    <= err_s2;
			done_s3   <= done_s2;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/pps_drive.sv -----
// Term sum, scaling toward zero, clamp and result register.
`default_nettype none
module pps_drive import pps_pkg::*; #(
	parameter int POSITION_WIDTH     = 32,
	parameter int INTEG_WIDTH        = 34,
	parameter int GAIN_FRACTION_BITS = 12
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en_s4,
	input  wire logic                                   en_out,
	input  wire logic                                   vld,
	input  wire logic [OLIM_W-1:0]                      output_limit,
	input  wire logic signed [POSITION_WIDTH+GAIN_W:0]  prod_p_s3,
	input  wire logic signed [POSITION_WIDTH+GAIN_W:0]  prod_d_s3,
	input  wire logic signed [INTEG_WIDTH+GAIN_W:0]     prod_i_s3,
	input  wire logic signed [POSITION_WIDTH-1:0]       err_s3,
	input  wire logic                                   done_s3,
	output logic signed [DRIVE_W-1:0]                   drive_q,
	output logic signed [POSITION_WIDTH-1:0]            err_q,
	output logic                                        done_q
);

	localparam int SW = INTEG_WIDTH + GAIN_W + 3;
	localparam int SH = GAIN_FRACTION_BITS + 10;

	logic signed [SW-1:0]       sum_s4;
	logic signed [POSITION_WIDTH-1:0] err_s4;
	logic                       done_s4;

	logic signed [SW-1:0]       scaled;
	logic signed [SW-1:0]       lim;
	logic signed [SW-1:0]       clamped;
	logic signed [DRIVE_W-1:0]  drive_d;
	logic [DRIVE_W-1:0]         drive_mag;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sum_s4  <= SW'(prod_p_s3) + SW'(prod_d_s3) + SW'(prod_i_s3);
			err_s4  <= err_s3;
			done_s4 <= done_s3;
		end
	end

	always_comb begin
		scaled = sum_s4 >>> SH;
		if (sum_s4[SW-1] && (|sum_s4[SH-1:0])) begin
			scaled = scaled + SW'(1);
		end
		lim = SW'({1'b0, output_limit});
		if (scaled > lim) begin
			clamped = lim;
		end else if (scaled < -lim) begin
			clamped = -lim;
		end else begin
			clamped = scaled;
		end
		drive_d = done_s4 ? '0 : clamped[DRIVE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			drive_q <= drive_d;
			err_q   <= err_s4;
			done_q  <= done_s4;
		end
	end

	assign drive_mag = drive_q[DRIVE_W-1] ? DRIVE_W'(-drive_q) : drive_q;

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld && done_q) |-> (drive_q == '0))
		else $error("nonzero drive while done");

	a_drive_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld |-> (drive_mag <= DRIVE_W'(output_limit)))
		else $error("drive beyond output limit");

endmodule
`default_nettype wire
